// File: rtl/bdpc_pkg.sv
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

    localparam int unsigned CfgW   = 16;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEBOUNCE  = 2'd0,
        REG_SHORT_MAX = 2'd1,
        REG_LONG      = 2'd2
    } t_cfg_idx;

    localparam logic [CfgW-1:0] DebounceRst = 16'd15;
    localparam logic [CfgW-1:0] ShortMaxRst = 16'd1000;
    localparam logic [CfgW-1:0] LongRst     = 16'd3000;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] short_max_ms;
        logic [CfgW-1:0] long_ms;
    } t_cfg;

    typedef struct packed {
        logic press;
        logic short_press;
        logic release_ev;
        logic long_press;
        logic stable;
    } t_events;

endpackage

// File: rtl/button_debounce_press_classifier_top.sv
// Top level: request channels, configuration registers and result register.
//
// Debouncer and short/long press classifier for one active-low button.
// Input channel (i_in_valid / o_in_ready): one request per poll, carrying
// the raw pin level (0 pressed) and a free-running 32-bit ms timestamp.
// Output channel (o_out_valid / i_out_ready): one result per request with
// press, short, release and long flags and the debounced level.
// Path: the accepting edge fills the input register; the state update and
// classification then read it, and the result register is loaded from them
// once it is free, so a stall keeps the request in the input register.
// Throughput: one request per cycle when unstalled; the state update is a single pass
// of three 32-bit subtract-and-compare paths, so the state loop closes each cycle.
// Stalls: if the receiver holds i_out_ready low, the result register holds
// and the input register keeps its request; o_in_ready drops only once both
// are full, and the state advances only as a request enters the result register.
// Reset (i_rst_n low, synchronous): both registers empty, button state
// released, timers disarmed, registers back to 15 / 1000 / 3000 ms.
// Configuration: write i_cfg_we with i_cfg_idx and i_cfg_data while idle;
// index 3 is ignored.
module button_debounce_press_classifier_top
    import bdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_pin_level,
    input  logic [TimeW-1:0]   i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_press_event,
    output logic               o_short_event,
    output logic               o_release_event,
    output logic               o_long_event,
    output logic               o_stable_out
);

    t_cfg             r_cfg;
    logic             r_in_vld;
    logic             r_pin;
    logic [TimeW-1:0] r_now;
    logic             r_out_vld;
    t_events          r_ev;
    t_events          ev;
    logic             out_free;
    logic             step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms  <= DebounceRst;
            r_cfg.short_max_ms <= ShortMaxRst;
            r_cfg.long_ms      <= LongRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE:  r_cfg.debounce_ms  <= i_cfg_data;
                REG_SHORT_MAX: r_cfg.short_max_ms <= i_cfg_data;
                REG_LONG:      r_cfg.long_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result register can take a new value when empty or being drained
    assign out_free   = !r_out_vld || i_out_ready;
    assign step       = r_in_vld && out_free;
    assign o_in_ready = !r_in_vld || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pin <= i_pin_level;
            r_now <= i_now_ms;
        end
    end

    bdpc_classifier u_classifier (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_pin_level (r_pin),
        .i_now_ms    (r_now),
        .i_cfg       (r_cfg),
        .o_events    (ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_ev <= ev;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_press_event   = r_ev.press;
    assign o_short_event   = r_ev.short_press;
    assign o_release_event = r_ev.release_ev;
    assign o_long_event    = r_ev.long_press;
    assign o_stable_out    = r_ev.stable;

    // a stalled result must not be overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready |=> r_out_vld && $stable(r_ev))
        else $error("stalled result changed");

    // an accepted request is never dropped while the input register is full
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !out_free |=> r_in_vld && $stable(r_now))
        else $error("pending request lost");

    // press and release never come together
    a_press_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_ev.press && r_ev.release_ev))
        else $error("press and release in one result");

endmodule

// File: rtl/bdpc_classifier.sv
// Debounce and press classification state, updated once per request.
module bdpc_classifier
    import bdpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_pin_level,
    input  logic [TimeW-1:0] i_now_ms,
    input  t_cfg             i_cfg,
    output t_events          o_events
);

    logic             r_raw, n_raw;
    logic             r_settling, n_settling;
    logic [TimeW-1:0] r_settle_start, n_settle_start;
    logic             r_stable, n_stable;
    logic             r_armed, n_armed;
    logic [TimeW-1:0] r_press_start, n_press_start;

    logic             raw_chg;
    logic             settling_a;
    logic [TimeW-1:0] settle_diff;
    logic             settled;
    logic             edge_det;
    logic             ev_press, ev_release, ev_short, ev_long;
    logic [TimeW-1:0] hold;
    logic             armed_a;

    always_comb begin
        raw_chg        = i_pin_level != r_raw;
        n_raw          = i_pin_level;
        settling_a     = raw_chg | r_settling;
        n_settle_start = raw_chg ? i_now_ms : r_settle_start;
        settle_diff    = i_now_ms - n_settle_start;
        settled        = settling_a && (settle_diff >= {{(TimeW-CfgW){1'b0}}, i_cfg.debounce_ms});
        n_stable       = settled ? i_pin_level : r_stable;
        n_settling     = settling_a & ~settled;

        edge_det   = n_stable != r_stable;
        ev_press   = edge_det & ~n_stable;
        ev_release = edge_det & n_stable;

        // hold time is zero on the poll that starts the press
        hold     = ev_press ? '0 : (i_now_ms - r_press_start);
        ev_short = ev_release && (hold <= {{(TimeW-CfgW){1'b0}}, i_cfg.short_max_ms});

        armed_a  = ev_press | (r_armed & ~ev_release);
        ev_long  = armed_a && (hold >= {{(TimeW-CfgW){1'b0}}, i_cfg.long_ms});
        n_armed  = armed_a & ~ev_long;
        n_press_start = ev_press ? i_now_ms : r_press_start;

        o_events.press       = ev_press;
        o_events.short_press = ev_short;
        o_events.release_ev  = ev_release;
        o_events.long_press  = ev_long;
        o_events.stable      = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw          <= 1'b1;
            r_settling     <= 1'b0;
            r_settle_start <= '0;
            r_stable       <= 1'b1;
            r_armed        <= 1'b0;
            r_press_start  <= '0;
        end else if (i_step) begin
            r_raw          <= n_raw;
            r_settling     <= n_settling;
            r_settle_start <= n_settle_start;
            r_stable       <= n_stable;
            r_armed        <= n_armed;
            r_press_start  <= n_press_start;
        end
    end

    // short press only ever comes with a release
    a_short_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ev_short |-> ev_release)
        else $error("short press without release");

    // no level change without a pending settle
    a_stable_needs_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !r_settling && (i_pin_level == r_raw) |-> (n_stable == r_stable))
        else $error("stable level moved while not settling");

    // a press that does not fire long at once leaves the hold timer armed
    a_press_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ev_press && !ev_long |=> r_armed)
        else $error("press did not arm hold timer");

    // long press needs the button held down
    a_long_when_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && ev_long |-> !n_stable)
        else $error("long press while released");

endmodule

// File: test/bdpc_event_checker.sv
// Event checker: predicts each poll's result and compares it with the block's output.
module bdpc_event_checker
    import bdpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [CfgW-1:0]    i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_pin_level,
    input  logic [TimeW-1:0]   i_now_ms,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic               i_press_event,
    input  logic               i_short_event,
    input  logic               i_release_event,
    input  logic               i_long_event,
    input  logic               i_stable_out,
    output int                 o_fail_count,
    output int                 o_pending
);

    t_cfg             cfg;
    logic             pin_held;
    logic             debouncing;
    logic [TimeW-1:0] bounce_t0;
    logic             level_stable;
    logic             level_prev;
    logic             hold_live;
    logic [TimeW-1:0] hold_t0;

    t_events          awaited_events[$];
    int               fails = 0;
    int               outstanding = 0;

    assign o_fail_count = fails;
    assign o_pending    = outstanding;

    // One poll of the button: updates the debounce and hold state, returns the flags.
    function automatic t_events classify_poll(input logic pin, input logic [TimeW-1:0] now);
        t_events          ev;
        logic [TimeW-1:0] since_edge;
        logic [TimeW-1:0] held_for;
        ev = '0;
        if (pin != pin_held) begin
            pin_held   = pin;
            debouncing = 1'b1;
            bounce_t0  = now;
        end
        since_edge = now - bounce_t0;
        if (debouncing && since_edge >= TimeW'(cfg.debounce_ms)) begin
            level_stable = pin_held;
            debouncing   = 1'b0;
        end
        if (level_stable != level_prev) begin
            held_for = now - hold_t0;
            if (!level_stable) begin
                hold_live = 1'b1;
                ev.press  = 1'b1;
                hold_t0   = now;
            end else begin
                ev.short_press = (held_for <= TimeW'(cfg.short_max_ms));
                ev.release_ev  = 1'b1;
                hold_live      = 1'b0;
            end
            level_prev = level_stable;
        end
        held_for = now - hold_t0;
        if (hold_live && held_for >= TimeW'(cfg.long_ms)) begin
            ev.long_press = 1'b1;
            hold_live     = 1'b0;
        end
        ev.stable = level_stable;
        return ev;
    endfunction

    task automatic check_flag(input string field, input logic want, input logic got);
        if (want !== got) begin
            $error("%s mismatch: expected %0b, got %0b", field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_events want;
        if (!i_rst_n) begin
            cfg.debounce_ms  = DebounceRst;
            cfg.short_max_ms = ShortMaxRst;
            cfg.long_ms      = LongRst;
            pin_held         = 1'b1;
            debouncing       = 1'b0;
            bounce_t0        = '0;
            level_stable     = 1'b1;
            level_prev       = 1'b1;
            hold_live        = 1'b0;
            hold_t0          = '0;
            awaited_events.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_DEBOUNCE:  cfg.debounce_ms  = i_cfg_data;
                    REG_SHORT_MAX: cfg.short_max_ms = i_cfg_data;
                    REG_LONG:      cfg.long_ms      = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                awaited_events.push_back(classify_poll(i_pin_level, i_now_ms));
            if (i_out_valid && i_out_ready) begin
                if (awaited_events.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = awaited_events.pop_front();
                    check_flag("press_event",   want.press,       i_press_event);
                    check_flag("short_event",   want.short_press, i_short_event);
                    check_flag("release_event", want.release_ev,  i_release_event);
                    check_flag("long_event",    want.long_press,  i_long_event);
                    check_flag("stable_out",    want.stable,      i_stable_out);
                end
            end
        end
        outstanding = awaited_events.size();
    end

endmodule

// File: test/button_debounce_press_classifier_top_tb.sv
// Testbench top: drives polls and register writes into the button classifier and reports.
module button_debounce_press_classifier_top_tb;
    import bdpc_pkg::*;

    // Generous ceiling on the run, counted in clock cycles.
    localparam int CycleLimit = 300000;
    // Index past the end of the register list; writes to it must be ignored.
    localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [CfgIdxW-1:0] cfg_idx    = '0;
    logic [CfgW-1:0]    cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               pin_level  = 1'b1;
    logic [TimeW-1:0]   now_ms     = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               press_event;
    logic               short_event;
    logic               release_event;
    logic               long_event;
    logic               stable_out;

    int                 fail_count;
    int                 pending;
    int                 cycle_count   = 0;
    int                 snd_idle_pct  = 0;
    int                 rcv_idle_pct  = 0;
    int                 phase_polls   = 0;

    // Stimulus-side view of the settings and of what has been sent. Only used to
    // shape well-formed clicks; prediction lives entirely in the checker.
    int                 dbn_ms        = int'(DebounceRst);
    int                 short_ms      = int'(ShortMaxRst);
    int                 long_ms_cfg   = int'(LongRst);
    logic [TimeW-1:0]   ms_now        = '0;
    logic               last_pin      = 1'b1;
    logic [TimeW-1:0]   last_edge_ms  = '0;

    button_debounce_press_classifier_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_pin_level     (pin_level),
        .i_now_ms        (now_ms),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_press_event   (press_event),
        .o_short_event   (short_event),
        .o_release_event (release_event),
        .o_long_event    (long_event),
        .o_stable_out    (stable_out)
    );

    bdpc_event_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_pin_level     (pin_level),
        .i_now_ms        (now_ms),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_press_event   (press_event),
        .i_short_event   (short_event),
        .i_release_event (release_event),
        .i_long_event    (long_event),
        .i_stable_out    (stable_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Receiver back-pressure: decided afresh on every falling edge.
    always @(negedge clk) begin
        out_ready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // All tasks start and end just after a falling edge.

    // Register write. The block must be idle, so drop valid and let every
    // outstanding result drain first; each poll gives a result, so once the
    // checker has nothing outstanding the block has nothing in flight.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            REG_DEBOUNCE:  dbn_ms      = int'(val);
            REG_SHORT_MAX: short_ms    = int'(val);
            REG_LONG:      long_ms_cfg = int'(val);
            default: ;
        endcase
    endtask

    task automatic set_regs(input int dbn, input int shrt, input int lng);
        write_reg(REG_DEBOUNCE,  CfgW'(dbn));
        write_reg(REG_SHORT_MAX, CfgW'(shrt));
        write_reg(REG_LONG,      CfgW'(lng));
    endtask

    // One poll request. Sender gaps are inserted first; valid then stays high
    // with the payload held until the request is taken.
    task automatic poll(input logic pin, input logic [TimeW-1:0] stamp);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        pin_level = pin;
        now_ms    = stamp;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (pin != last_pin) begin
            last_pin     = pin;
            last_edge_ms = stamp;
        end
        ms_now = stamp;
        phase_polls++;
    endtask

    // Junk polls: random levels with random, slightly later or earlier stamps.
    task automatic poll_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(0, 2))
                0:       poll(1'($urandom_range(0, 1)), $urandom());
                1:       poll(1'($urandom_range(0, 1)), ms_now + $urandom_range(0, 30));
                default: poll(1'($urandom_range(0, 1)), ms_now - $urandom_range(1, 5000));
            endcase
        end
    endtask

    // A whole click: bouncy press, steady hold of a chosen length, bouncy
    // release. Hold lengths cluster round the short and long thresholds.
    task automatic run_click();
        logic [TimeW-1:0] t_press;
        int               d;
        int               hold_end;
        int               cur_off;
        int               room;
        int               k;

        k = $urandom_range(0, 3);
        repeat (k) poll(1'($urandom_range(0, 1)), ms_now + $urandom_range(1, 4));
        poll(1'b0, ms_now + 1);
        if ($urandom_range(0, 2) != 0)
            poll(1'b0, ms_now + $urandom_range(1, dbn_ms));
        if ($urandom_range(0, 2) == 0)
            poll(1'b0, last_edge_ms + dbn_ms + $urandom_range(1, 20));
        else
            poll(1'b0, last_edge_ms + dbn_ms);
        t_press = ms_now;

        case ($urandom_range(0, 5))
            0:       d = $urandom_range(0, short_ms);
            1:       d = short_ms + int'($urandom_range(0, 2)) - 1;
            2:       d = long_ms_cfg + int'($urandom_range(0, 2)) - 1;
            3:       d = $urandom_range(0, long_ms_cfg + 500);
            default: d = $urandom_range(0, 70000);
        endcase
        // Hold measured to the settled release poll, so the raw release comes
        // one debounce time earlier.
        if (d < dbn_ms + 8) d = dbn_ms + 8;
        hold_end = d - dbn_ms;

        cur_off = 0;
        if ($urandom_range(0, 1) == 1 && long_ms_cfg > 0 && long_ms_cfg < hold_end - 4) begin
            poll(1'b0, t_press + long_ms_cfg);
            cur_off = long_ms_cfg;
        end
        k = $urandom_range(0, 3);
        repeat (k) begin
            room = (hold_end - 4 - cur_off) / 2;
            if (room >= 1) begin
                cur_off += $urandom_range(1, room);
                poll(1'b0, t_press + cur_off);
            end
        end

        if ($urandom_range(0, 1) == 1) begin
            poll(1'b1, t_press + hold_end - 3);
            poll(1'b0, t_press + hold_end - 2);
        end
        poll(1'b1, t_press + hold_end);
        poll(1'b1, t_press + hold_end + dbn_ms);
        if ($urandom_range(0, 1) == 1)
            poll(1'b1, ms_now + $urandom_range(0, 50));
    endtask

    initial begin
        int ph;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // ---- Directed part ----
        // Reset settings (15 / 1000 / 3000). Press straddling the timestamp
        // wrap, long press, then release well past the short limit.
        poll(1'b1, 32'd0);
        poll(1'b0, 32'hFFFF_FFF8);
        poll(1'b0, 32'd7);
        poll(1'b0, 32'd3007);
        poll(1'b1, 32'd3010);
        poll(1'b1, 32'd3025);

        // Zero debounce and zero long time: press and long in the same poll;
        // the spare index must leave everything untouched.
        set_regs(0, 65535, 0);
        write_reg(RegSpare, 16'hFFFF);
        poll(1'b0, 32'd100);
        poll(1'b1, 32'd200);
        poll(1'b1, 32'd300);

        // Largest debounce, zero short limit; release accepted on a timestamp
        // that has gone backwards, which reads as a very long interval.
        set_regs(65535, 0, 65535);
        poll(1'b0, 32'd1000);
        poll(1'b0, 32'd66534);
        poll(1'b0, 32'd66535);
        poll(1'b1, 32'd66535);
        poll(1'b1, 32'd500);

        // Release after a long press still earns a short press if within the
        // limit; then a hold exactly at the limit and one just beyond it.
        set_regs(5, 50, 10);
        poll(1'b0, 32'hFFFF_FFFF);
        poll(1'b0, 32'd4);
        poll(1'b0, 32'd14);
        poll(1'b1, 32'd20);
        poll(1'b1, 32'd25);
        poll(1'b0, 32'd30);
        poll(1'b0, 32'd35);
        poll(1'b1, 32'd80);
        poll(1'b1, 32'd85);
        poll(1'b0, 32'd90);
        poll(1'b0, 32'd95);
        poll(1'b1, 32'd141);
        poll(1'b1, 32'd146);

        // ---- Random part: three phases of idling, each with fresh settings ----
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 34;
                    rcv_idle_pct = 64;
                    set_regs($urandom_range(0, 40), $urandom_range(50, 1500),
                             $urandom_range(100, 4000));
                end
                1: begin
                    snd_idle_pct = 64;
                    rcv_idle_pct = 34;
                    set_regs(0, 65535, $urandom_range(0, 300));
                    write_reg(RegSpare, CfgW'($urandom()));
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                    set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                end
            endcase
            phase_polls = 0;
            while (phase_polls < 135) begin
                if ($urandom_range(0, 99) < 20)
                    poll_noise();
                else
                    run_click();
            end
        end

        // Drain: nothing outstanding, then idle on so that stray results show.
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
